// ===== sv/delta_sleep_timer_queue_macros.svh =====
// Assertion macros used by the delta sleep timer queue datapath.
// Plain SystemVerilog; no other dependencies.
`ifndef DELTA_SLEEP_TIMER_QUEUE_MACROS_SVH
`define DELTA_SLEEP_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSTQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dstq_pkg.sv =====
// Package for the delta sleep timer queue: sizes, codes and the command and
// status structs that join the controller and the datapath. No dependencies.
`timescale 1ns / 1ps

package dstq_pkg;

  localparam int DEPTH      = 16;
  localparam int TIME_WIDTH = 16;
  localparam int TASK_WIDTH = 16;
  localparam int SLEEP_WIDTH = 16;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WIDE_W = (TIME_WIDTH > SLEEP_WIDTH) ? TIME_WIDTH : SLEEP_WIDTH;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [TASK_WIDTH-1:0] task_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  // Input word kinds.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Result word kinds and insert status codes.
  localparam logic RES_STATUS = 1'b0;
  localparam logic RES_WOKEN  = 1'b1;
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_FULL    = 1'b1;

  localparam logic [WIDE_W-1:0] TIME_MAX_W =
    WIDE_W'((64'd1 << TIME_WIDTH) - 64'd1);

  typedef struct packed {
    logic load;          // capture the input word
    logic walk_step;     // one step of the insert walk
    logic shift_step;    // one step of the make-room shift, or the final write
    logic tick_dec;      // decrement the head entry
    logic wake_emit;     // emit one woken task
    logic compact_step;  // one step of closing the gap after a wake
    logic emit_resp;     // emit the insert status
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic walk_stop;
    logic shift_done;
    logic expire;
    logic wake_last;
    logic compact_done;
    logic out_free;
  } sts_t;

  // Zero sleeps one tick; values wider than the time field saturate.
  function automatic time_t sat_time(input logic [SLEEP_WIDTH-1:0] s);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(s);
    if (w == '0) begin
      w = WIDE_W'(1);
    end
    if (w > TIME_MAX_W) begin
      w = TIME_MAX_W;
    end
    return time_t'(w);
  endfunction

endpackage

// ===== sv/dstq_ctrl.sv =====
// Controller state machine of the delta sleep timer queue.
// Depends on dstq_pkg for the command and status structs and the word codes.
`timescale 1ns / 1ps

module dstq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_kind_i,
  output logic          in_stall_o,
  input  dstq_pkg::sts_t sts_i,
  output dstq_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_WALK    = 7'b0000010,
    S_SHIFT   = 7'b0000100,
    S_RESP    = 7'b0001000,
    S_TICK    = 7'b0010000,
    S_WAKE    = 7'b0100000,
    S_COMPACT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_kind_i == dstq_pkg::KIND_INSERT) begin
            state_d = sts_i.full ? S_RESP : S_WALK;
          end else begin
            state_d = sts_i.empty ? S_IDLE : S_TICK;
          end
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_stop) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.shift_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.emit_resp = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_TICK: begin
        cmd_o.tick_dec = 1'b1;
        state_d = sts_i.expire ? S_WAKE : S_IDLE;
      end
      S_WAKE: begin
        if (sts_i.out_free) begin
          cmd_o.wake_emit = 1'b1;
          if (sts_i.wake_last) begin
            state_d = S_COMPACT;
          end
        end
      end
      S_COMPACT: begin
        cmd_o.compact_step = 1'b1;
        if (sts_i.compact_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/dstq_dp.sv =====
// Datapath of the delta sleep timer queue: entry store, walk and shift
// counters, head arithmetic and the output register. Depends on dstq_pkg and the macros header.
`timescale 1ns / 1ps
`include "delta_sleep_timer_queue_macros.svh"

module dstq_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dstq_pkg::cmd_t                      cmd_i,
  output dstq_pkg::sts_t                      sts_o,
  input  logic [dstq_pkg::TASK_WIDTH-1:0]     task_id_i,
  input  logic [dstq_pkg::SLEEP_WIDTH-1:0]    sleep_ticks_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                result_kind_o,
  output logic                                status_o,
  output logic [dstq_pkg::TASK_WIDTH-1:0]     woken_id_o,
  output logic                                last_o
);

  dstq_pkg::task_t task_mem  [dstq_pkg::DEPTH];
  dstq_pkg::time_t delta_mem [dstq_pkg::DEPTH];

  dstq_pkg::cnt_t  count_q, count_d;
  dstq_pkg::cnt_t  ptr_q, ptr_d;
  dstq_pkg::cnt_t  sh_q, sh_d;
  dstq_pkg::cnt_t  src_q, src_d;
  dstq_pkg::cnt_t  dst_q, dst_d;
  dstq_pkg::time_t t_q, t_d;
  dstq_pkg::task_t id_q, id_d;
  logic            fail_q, fail_d;

  logic            out_valid_q, out_valid_d;
  logic            out_kind_q, out_kind_d;
  logic            out_status_q, out_status_d;
  dstq_pkg::task_t out_id_q, out_id_d;
  logic            out_last_q, out_last_d;

  dstq_pkg::idx_t  rd_task_addr, rd_delta_addr;
  dstq_pkg::task_t rd_task;
  dstq_pkg::time_t rd_delta;

  dstq_pkg::idx_t  wr_addr;
  logic            wr_task_en, wr_delta_en;
  dstq_pkg::task_t wr_task;
  dstq_pkg::time_t wr_delta;

  dstq_pkg::cnt_t  ptr_inc;
  logic            ptr_lt_n, walk_adv, out_free;
  dstq_pkg::time_t head_dec;

  assign ptr_inc  = ptr_q + dstq_pkg::cnt_t'(1);
  assign ptr_lt_n = (ptr_q < count_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // Read address selection: one task read and one delta read per cycle.
  always_comb begin
    rd_task_addr  = ptr_q[dstq_pkg::IDX_W-1:0];
    rd_delta_addr = ptr_q[dstq_pkg::IDX_W-1:0];
    if (cmd_i.shift_step) begin
      rd_task_addr  = dstq_pkg::IDX_W'(sh_q - dstq_pkg::cnt_t'(1));
      rd_delta_addr = dstq_pkg::IDX_W'(sh_q - dstq_pkg::cnt_t'(1));
    end else if (cmd_i.compact_step) begin
      rd_task_addr  = src_q[dstq_pkg::IDX_W-1:0];
      rd_delta_addr = src_q[dstq_pkg::IDX_W-1:0];
    end else if (cmd_i.wake_emit) begin
      rd_delta_addr = ptr_inc[dstq_pkg::IDX_W-1:0];
    end else if (cmd_i.tick_dec) begin
      rd_delta_addr = '0;
    end
  end

  assign rd_task  = task_mem[rd_task_addr];
  assign rd_delta = delta_mem[rd_delta_addr];

  // The head compares with >= so that a tie lands after it; later entries
  // use > so that a tie lands before the entry it ties with.
  assign walk_adv = ptr_lt_n &&
                    ((ptr_q == '0) ? (t_q >= rd_delta) : (t_q > rd_delta));
  assign head_dec = (rd_delta == '0) ? '0 : rd_delta - dstq_pkg::time_t'(1);

  always_comb begin
    sts_o.full         = (count_q == dstq_pkg::CNT_W'(dstq_pkg::DEPTH));
    sts_o.empty        = (count_q == '0);
    sts_o.walk_stop    = !walk_adv;
    sts_o.shift_done   = (sh_q == ptr_q);
    sts_o.expire       = (head_dec == '0);
    sts_o.wake_last    = !((ptr_inc < count_q) && (rd_delta == '0));
    sts_o.compact_done = (src_q >= count_q);
    sts_o.out_free     = out_free;
  end

  always_comb begin
    count_d = count_q;
    ptr_d   = ptr_q;
    sh_d    = sh_q;
    src_d   = src_q;
    dst_d   = dst_q;
    t_d     = t_q;
    id_d    = id_q;
    fail_d  = fail_q;

    wr_addr     = ptr_q[dstq_pkg::IDX_W-1:0];
    wr_task_en  = 1'b0;
    wr_delta_en = 1'b0;
    wr_task     = rd_task;
    wr_delta    = rd_delta;

    out_valid_d  = out_valid_q && out_stall_i;
    out_kind_d   = out_kind_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_last_d   = out_last_q;

    if (cmd_i.load) begin
      id_d   = task_id_i;
      t_d    = dstq_pkg::sat_time(sleep_ticks_i);
      ptr_d  = '0;
      fail_d = sts_o.full;
    end

    if (cmd_i.walk_step) begin
      if (walk_adv) begin
        t_d   = t_q - rd_delta;
        ptr_d = ptr_inc;
      end else begin
        sh_d = count_q;
        if (ptr_lt_n) begin
          wr_delta_en = 1'b1;
          wr_delta    = rd_delta - t_q;
        end
      end
    end

    if (cmd_i.shift_step) begin
      wr_task_en  = 1'b1;
      wr_delta_en = 1'b1;
      if (sh_q > ptr_q) begin
        wr_addr = sh_q[dstq_pkg::IDX_W-1:0];
        sh_d    = sh_q - dstq_pkg::cnt_t'(1);
      end else begin
        wr_task  = id_q;
        wr_delta = t_q;
        count_d  = count_q + dstq_pkg::cnt_t'(1);
      end
    end

    if (cmd_i.tick_dec) begin
      wr_addr     = '0;
      wr_delta_en = 1'b1;
      wr_delta    = head_dec;
    end

    if (cmd_i.wake_emit) begin
      out_valid_d  = 1'b1;
      out_kind_d   = dstq_pkg::RES_WOKEN;
      out_status_d = dstq_pkg::ST_OK;
      out_id_d     = rd_task;
      out_last_d   = sts_o.wake_last;
      ptr_d        = ptr_inc;
      if (sts_o.wake_last) begin
        src_d = ptr_inc;
        dst_d = '0;
      end
    end

    if (cmd_i.compact_step) begin
      if (sts_o.compact_done) begin
        count_d = dst_q;
      end else begin
        wr_addr     = dst_q[dstq_pkg::IDX_W-1:0];
        wr_task_en  = 1'b1;
        wr_delta_en = 1'b1;
        src_d       = src_q + dstq_pkg::cnt_t'(1);
        dst_d       = dst_q + dstq_pkg::cnt_t'(1);
      end
    end

    if (cmd_i.emit_resp) begin
      out_valid_d  = 1'b1;
      out_kind_d   = dstq_pkg::RES_STATUS;
      out_status_d = fail_q ? dstq_pkg::ST_FULL : dstq_pkg::ST_OK;
      out_id_d     = '0;
      out_last_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    sh_q         <= sh_d;
    src_q        <= src_d;
    dst_q        <= dst_d;
    t_q          <= t_d;
    id_q         <= id_d;
    fail_q       <= fail_d;
    out_kind_q   <= out_kind_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_task_en) begin
      task_mem[wr_addr] <= wr_task;
    end
    if (wr_delta_en) begin
      delta_mem[wr_addr] <= wr_delta;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign status_o      = out_status_q;
  assign woken_id_o    = out_id_q;
  assign last_o        = out_last_q;

  `DSTQ_ASSERT_IMPL(a_count_range, clk_i, rst_ni, 1'b1,
    count_q <= dstq_pkg::CNT_W'(dstq_pkg::DEPTH), "entry count exceeds depth")
  `DSTQ_ASSERT_IMPL(a_emit_when_free, clk_i, rst_ni,
    cmd_i.wake_emit || cmd_i.emit_resp, out_free, "result emitted over a held word")
  `DSTQ_ASSERT_NEXT(a_shift_from_tail, clk_i, rst_ni,
    cmd_i.walk_step && !walk_adv, sh_q == $past(count_q), "shift does not start at tail")
  `DSTQ_ASSERT_IMPL(a_compact_order, clk_i, rst_ni,
    cmd_i.compact_step && !sts_o.compact_done, dst_q < src_q, "compaction overruns source")

endmodule

// ===== sv/delta_sleep_timer_queue.sv =====
// Top level of the delta sleep timer queue: controller plus datapath.
// Depends on dstq_pkg, dstq_ctrl and dstq_dp.
//
//   Channel | Direction | Handshake              | Words
//   --------+-----------+------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_stall_o | kind_i, task_id_i, sleep_ticks_i
//   out     | output    | out_valid_o/out_stall_i | result_kind_o, status_o, woken_id_o,
//           |           |                        | last_o
//
// An insert is accepted, walks the list, shifts the entries behind its place, writes
// itself and issues the status word; a full list skips straight to the status word.
// A tick decrements any head; on expiry it issues each woken task, then closes the gap.
// The entry store has a single write port, so shifts and compaction go entry by entry.
// Reset empties the queue at once; there is no clearing pass.
// A stalled output only holds the controller when it has a further word to issue.
`timescale 1ns / 1ps

module delta_sleep_timer_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             kind_i,
  input  logic [dstq_pkg::TASK_WIDTH-1:0]  task_id_i,
  input  logic [dstq_pkg::SLEEP_WIDTH-1:0] sleep_ticks_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             result_kind_o,
  output logic                             status_o,
  output logic [dstq_pkg::TASK_WIDTH-1:0]  woken_id_o,
  output logic                             last_o
);

  // The controller sequences each insert through the walk, shift and status steps and each
  // tick through the tick, wake and compaction steps; the datapath reports back what it has found.
  dstq_pkg::cmd_t cmd;
  dstq_pkg::sts_t sts;

  dstq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (kind_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the delta list, in which the head entry carries its
  // absolute remaining ticks and every later entry the ticks after its
  // predecessor, and the output register that parts the two channels.
  dstq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .task_id_i     (task_id_i),
    .sleep_ticks_i (sleep_ticks_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .status_o      (status_o),
    .woken_id_o    (woken_id_o),
    .last_o        (last_o)
  );

endmodule

// ===== dv/delta_sleep_timer_queue_tb.sv =====
// Self-checking testbench for the delta sleep timer queue: a directed table, then
// random inserts and ticks under varying back-pressure, checked word by word.
// Depends on dstq_pkg and the delta_sleep_timer_queue RTL.
`timescale 1ns / 1ps

module delta_sleep_timer_queue_tb;

  // One result word as it leaves the block.
  typedef struct packed {
    logic            rkind;
    logic            status;
    dstq_pkg::task_t id;
    logic            last;
  } out_word_t;

  // How a directed row is checked: by the predictor, as causing no word at
  // all, or against the single word typed into the row.
  typedef enum logic [1:0] {
    CHECK_MODEL,
    CHECK_SILENT,
    CHECK_TYPED
  } check_e;

  typedef struct {
    logic                             kind;
    dstq_pkg::task_t                  id;
    logic [dstq_pkg::SLEEP_WIDTH-1:0] ticks;
    check_e                           chk;
    out_word_t                        typed;
  } stim_row_t;

  localparam out_word_t WORD_OK   = '{rkind: dstq_pkg::RES_STATUS,
                                      status: dstq_pkg::ST_OK, id: '0, last: 1'b1};
  localparam out_word_t WORD_FULL = '{rkind: dstq_pkg::RES_STATUS,
                                      status: dstq_pkg::ST_FULL, id: '0, last: 1'b1};
  localparam out_word_t WORD_NONE = '0;

  localparam longint unsigned TIME_LIMIT = (64'd1 << dstq_pkg::TIME_WIDTH) - 64'd1;

  // The worst gap between two accepted words is an insert walking and
  // shifting the full list plus the longest run of sender idling and
  // receiver stalling; the limit leaves a wide margin.
  localparam int WATCHDOG_LIMIT   = 2000;
  // Hold-off after the last expected word: a tick that wakes nothing can still be in flight.
  localparam int DRAIN_CYCLES     = dstq_pkg::DEPTH + 16;
  localparam int RANDOM_PER_PHASE = 37;

  logic                             clk_i;
  logic                             rst_ni        = 1'b0;
  logic                             in_valid_i    = 1'b0;
  logic                             in_stall_o;
  logic                             kind_i        = dstq_pkg::KIND_INSERT;
  dstq_pkg::task_t                  task_id_i     = '0;
  logic [dstq_pkg::SLEEP_WIDTH-1:0] sleep_ticks_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i   = 1'b0;
  logic                             result_kind_o;
  logic                             status_o;
  dstq_pkg::task_t                  woken_id_o;
  logic                             last_o;

  // Shadow copy of the sleep list: entry 0 holds the head's absolute
  // remaining ticks, every later entry its delta after the one before it.
  dstq_pkg::task_t list_task  [dstq_pkg::DEPTH];
  dstq_pkg::time_t list_delta [dstq_pkg::DEPTH];
  int              list_count = 0;

  out_word_t due_words [$];
  int        mismatch_count = 0;
  int        idle_cycles    = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  int send_idle_by_phase [4] = '{0, 86, 0, 36};
  int recv_stall_by_phase[4] = '{0, 0, 86, 36};

  // Directed part. Rows checked without the predictor are those whose answer is
  // plain: an insert that fits says ok, an insert into a full list says full, and a tick
  // on an empty list or one that cannot expire the head says nothing. Wakes go to the predictor.
  stim_row_t directed_rows [23] = '{
    // A tick on an empty list has no effect.
    '{dstq_pkg::KIND_TICK,   16'h0000, 16'h0000, CHECK_SILENT, WORD_NONE},
    // A zero sleep time counts as one tick, so the next tick wakes it.
    '{dstq_pkg::KIND_INSERT, 16'hFFFF, 16'h0000, CHECK_TYPED,  WORD_OK},
    '{dstq_pkg::KIND_TICK,   16'h0000, 16'hFFFF, CHECK_MODEL,  WORD_NONE},
    // Largest sleep time, then an insert ahead of the head.
    '{dstq_pkg::KIND_INSERT, 16'h0000, 16'hFFFF, CHECK_TYPED,  WORD_OK},
    '{dstq_pkg::KIND_INSERT, 16'h0001, 16'h0002, CHECK_TYPED,  WORD_OK},
    // A tie with the head goes behind it with a zero delta.
    '{dstq_pkg::KIND_INSERT, 16'h0002, 16'h0002, CHECK_TYPED,  WORD_OK},
    '{dstq_pkg::KIND_INSERT, 16'h0003, 16'h0003, CHECK_TYPED,  WORD_OK},
    // A tie further along goes in front of the entry it ties with.
    '{dstq_pkg::KIND_INSERT, 16'h0004, 16'h0003, CHECK_TYPED,  WORD_OK},
    // Fill the list to capacity; nothing here sleeps less than three ticks.
    '{dstq_pkg::KIND_INSERT, 16'h8000, 16'h000A, CHECK_TYPED,  WORD_OK},
    '{dstq_pkg::KIND_INSERT, 16'h7FFF, 16'h0FA0, CHECK_TYPED,  WORD_OK},
    '{dstq_pkg::KIND_INSERT, 16'hAAAA, 16'h8000, CHECK_TYPED,  WORD_OK},
    '{dstq_pkg::KIND_INSERT, 16'h5555, 16'hFFFE, CHECK_TYPED,  WORD_OK},
    '{dstq_pkg::KIND_INSERT, 16'h0010, 16'h0003, CHECK_TYPED,  WORD_OK},
    '{dstq_pkg::KIND_INSERT, 16'h0011, 16'h0032, CHECK_TYPED,  WORD_OK},
    '{dstq_pkg::KIND_INSERT, 16'h0012, 16'h00C8, CHECK_TYPED,  WORD_OK},
    '{dstq_pkg::KIND_INSERT, 16'h0013, 16'h0007, CHECK_TYPED,  WORD_OK},
    '{dstq_pkg::KIND_INSERT, 16'h0014, 16'h0009, CHECK_TYPED,  WORD_OK},
    // Inside the list: these land between existing entries and fill it to capacity.
    '{dstq_pkg::KIND_INSERT, 16'h0015, 16'h012C, CHECK_TYPED,  WORD_OK},
    '{dstq_pkg::KIND_INSERT, 16'h0016, 16'h5555, CHECK_TYPED,  WORD_OK},
    // The list is full now, so this insert is dropped.
    '{dstq_pkg::KIND_INSERT, 16'h1234, 16'h0001, CHECK_TYPED,  WORD_FULL},
    // The head has two ticks left: the first tick only counts down.
    '{dstq_pkg::KIND_TICK,   16'hFFFF, 16'h0000, CHECK_SILENT, WORD_NONE},
    // The second wakes the head and its zero-delta follower together.
    '{dstq_pkg::KIND_TICK,   16'h0000, 16'h0000, CHECK_MODEL,  WORD_NONE},
    // One more tick wakes a run of three tied entries.
    '{dstq_pkg::KIND_TICK,   16'h0000, 16'h0000, CHECK_MODEL,  WORD_NONE}
  };

  delta_sleep_timer_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .task_id_i     (task_id_i),
    .sleep_ticks_i (sleep_ticks_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .status_o      (status_o),
    .woken_id_o    (woken_id_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Applies one accepted input word to the shadow list and queues the words
  // that the block must return for it, in order.
  function automatic void advance_sleep_list(input logic kind, input dstq_pkg::task_t id,
                                             input logic [dstq_pkg::SLEEP_WIDTH-1:0] ticks);
    longint unsigned wide_ticks;
    dstq_pkg::time_t t;
    int              pos;
    int              woken;
    out_word_t       w;
    if (kind == dstq_pkg::KIND_INSERT) begin
      if (list_count >= dstq_pkg::DEPTH) begin
        due_words.push_back(WORD_FULL);
        return;
      end
      wide_ticks = (ticks == '0) ? 64'd1 : 64'(ticks);
      if (wide_ticks > TIME_LIMIT) begin
        wide_ticks = TIME_LIMIT;
      end
      t = dstq_pkg::time_t'(wide_ticks);
      // Walk the deltas. A tie with the head lands behind it; further along,
      // a tie lands in front and leaves the entry behind with a zero delta.
      if (list_count == 0) begin
        pos = 0;
      end else if (t < list_delta[0]) begin
        pos = 0;
        list_delta[0] -= t;
      end else begin
        t -= list_delta[0];
        pos = 1;
        while (pos < list_count && t > list_delta[pos]) begin
          t -= list_delta[pos];
          pos++;
        end
        if (pos < list_count) begin
          list_delta[pos] -= t;
        end
      end
      for (int i = list_count; i > pos; i--) begin
        list_task[i]  = list_task[i-1];
        list_delta[i] = list_delta[i-1];
      end
      list_task[pos]  = id;
      list_delta[pos] = t;
      list_count++;
      due_words.push_back(WORD_OK);
    end else begin
      if (list_count == 0) begin
        return;
      end
      if (list_delta[0] != '0) begin
        list_delta[0] -= 1'b1;
      end
      if (list_delta[0] != '0) begin
        return;
      end
      // The head has expired: it and every zero-delta entry behind it wake.
      woken = 1;
      while (woken < list_count && list_delta[woken] == '0) begin
        woken++;
      end
      for (int i = 0; i < woken; i++) begin
        w.rkind  = dstq_pkg::RES_WOKEN;
        w.status = dstq_pkg::ST_OK;
        w.id     = list_task[i];
        w.last   = (i == woken - 1);
        due_words.push_back(w);
      end
      for (int i = woken; i < list_count; i++) begin
        list_task[i-woken]  = list_task[i];
        list_delta[i-woken] = list_delta[i];
      end
      list_count -= woken;
    end
  endfunction

  // Presents one input word after a random idle spell and returns at the
  // edge at which it is accepted. The predictor runs at that edge; for rows
  // with a fixed answer its words are dropped and any typed word queued instead.
  task automatic send_word(input logic kind, input dstq_pkg::task_t id,
                           input logic [dstq_pkg::SLEEP_WIDTH-1:0] ticks,
                           input check_e chk, input out_word_t typed);
    int queued_before;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    task_id_i     <= id;
    sleep_ticks_i <= ticks;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    queued_before = due_words.size();
    advance_sleep_list(kind, id, ticks);
    if (chk != CHECK_MODEL) begin
      while (due_words.size() > queued_before) begin
        void'(due_words.pop_back());
      end
    end
    if (chk == CHECK_TYPED) begin
      due_words.push_back(typed);
    end
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every accepted result word is held against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word kind=%0b status=%0b id=%h last=%0b",
                                result_kind_o, status_o, woken_id_o, last_o));
      end else begin
        want = due_words.pop_front();
        if (result_kind_o !== want.rkind) begin
          flag_mismatch($sformatf("result_kind %0b, expected %0b", result_kind_o, want.rkind));
        end
        if (status_o !== want.status) begin
          flag_mismatch($sformatf("status %0b, expected %0b", status_o, want.status));
        end
        if (woken_id_o !== want.id) begin
          flag_mismatch($sformatf("woken_id %h, expected %h", woken_id_o, want.id));
        end
        if (last_o !== want.last) begin
          flag_mismatch($sformatf("last %0b, expected %0b", last_o, want.last));
        end
      end
    end
  end

  // Ends the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic                             kind;
    dstq_pkg::task_t                  id;
    logic [dstq_pkg::SLEEP_WIDTH-1:0] ticks;
    int                               counted;
    int                               item;
    int                               tick_pct;
    int                               roll;
    tick_pct = 35;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_word(directed_rows[r].kind, directed_rows[r].id, directed_rows[r].ticks,
                directed_rows[r].chk, directed_rows[r].typed);
    end

    // Random part, one phase per idling pattern. Each phase opens with the
    // sender held off until every outstanding word has come back.
    for (int phase = 0; phase < 4; phase++) begin
      in_valid_i <= 1'b0;
      do begin
        @(posedge clk_i);
      end while (due_words.size() != 0);
      send_idle_pct  = send_idle_by_phase[phase];
      recv_stall_pct = recv_stall_by_phase[phase];
      counted = 0;
      item    = 0;
      while (counted < RANDOM_PER_PHASE) begin
        // The tick rate drifts in bursts, so that the list can both fill to capacity
        // and drain back to empty within a phase.
        if (item % 12 == 0) begin
          roll     = $urandom_range(2);
          tick_pct = (roll == 0) ? 10 : (roll == 1) ? 35 : 65;
        end
        kind = ($urandom_range(99) < tick_pct) ? dstq_pkg::KIND_TICK : dstq_pkg::KIND_INSERT;
        id   = dstq_pkg::task_t'($urandom);
        // Mostly short sleeps so that ties and multi-task wakes are common.
        roll = $urandom_range(99);
        if (roll < 65) begin
          ticks = dstq_pkg::SLEEP_WIDTH'($urandom_range(6));
        end else if (roll < 90) begin
          ticks = dstq_pkg::SLEEP_WIDTH'($urandom_range(40));
        end else begin
          ticks = dstq_pkg::SLEEP_WIDTH'($urandom);
        end
        // A tick on an empty list is ignored by the block and not counted.
        if (kind == dstq_pkg::KIND_INSERT || list_count != 0) begin
          counted++;
        end
        send_word(kind, id, ticks, CHECK_MODEL, WORD_NONE);
        item++;
      end
    end

    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (due_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/dstq_pkg.sv
sv/dstq_ctrl.sv
sv/dstq_dp.sv
sv/delta_sleep_timer_queue.sv
dv/delta_sleep_timer_queue_tb.sv
